FILE: hw/rtl/frs_pkg.sv
// Shared types and constants for the FASTQ record statistics block.
`timescale 1ns / 1ps

package frs_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int TOTAL_BITS  = 40;

	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = QPTR_BITS + 1;

	localparam logic [7:0]  CH_AT    = 8'h40;
	localparam logic [7:0]  CH_NL    = 8'h0A;
	localparam logic [15:0] SEP_TAIL = 16'h0A2B;

	localparam logic [LENGTH_BITS-1:0] MIN_LEN_RESET = (LENGTH_BITS > 11) ?
		LENGTH_BITS'(2048) : {LENGTH_BITS{1'b1}};
	localparam logic [7:0] MIN_Q_RESET = 8'd127;

	typedef enum logic [2:0] {
		ST_DONE   = 3'd0,
		ST_END    = 3'd1,
		ST_NO_AT  = 3'd2,
		ST_NO_NL  = 3'd3,
		ST_NO_SEP = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_AWAIT = 3'd0,
		PH_TITLE = 3'd1,
		PH_SEQ   = 3'd2,
		PH_QUAL  = 3'd3,
		PH_NL    = 3'd4
	} phase_t;

	// One classified byte, as handed from the parser to the statistics side.
	typedef struct packed {
		logic                   last;
		logic                   emit;
		logic                   sep;
		logic                   qual;
		logic                   rec;
		status_t                status;
		logic [LENGTH_BITS-1:0] len;
		logic [7:0]             qbyte;
	} cmd_t;

endpackage

FILE: hw/rtl/fastq_record_statistics.sv
// Top level of the FASTQ record statistics block.
// Usage:
//   Input channel: one byte of decompressed FASTQ text per request on
//   data_byte, with is_last set on the final byte of a buffer. A request is
//   taken on a rising edge with in_valid high and in_stall low.
//   Output channel: one result per completed record, per parse error and
//   per last byte, taken on an edge with out_valid high and out_stall low.
//   Throughput: one byte per clock while in_stall is low. The parser and
//   the statistics side are split by a four-entry command queue; bytes
//   that change nothing are not queued, so the queue fills only while
//   out_stall holds a result back. Path: the edge that takes a byte writes
//   its command into the queue, from which the statistics side loads the
//   result into the output register that drives out_valid.
//   Receiver stall: the output register holds its result; quality and
//   separator updates keep draining, and in_stall rises once the queue fills.
//   Reset: arst_n clears parser phase, queue and all totals (shortest read
//   back to 2048, lowest quality back to 127). The last byte of a buffer
//   returns the same state after its summary result.
`timescale 1ns / 1ps

module fastq_record_statistics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] record_count,
	output logic [39:0] total_bases,
	output logic [15:0] longest_read,
	output logic [15:0] shortest_read,
	output logic [7:0]  highest_quality,
	output logic [7:0]  lowest_quality,
	output logic [15:0] record_length
);

	logic                          push_valid;
	logic                          push_stall;
	frs_pkg::cmd_t                 push_cmd;
	logic                          pop_valid;
	logic                          pop_stall;
	frs_pkg::cmd_t                 pop_cmd;
	logic [frs_pkg::QCNT_BITS-1:0] q_count;

	frs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.is_last    (is_last),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_cmd   (push_cmd)
	);

	frs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_cmd    (pop_cmd),
		.count      (q_count)
	);

	frs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_stall       (pop_stall),
		.pop_cmd         (pop_cmd),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.record_count    (record_count),
		.total_bases     (total_bases),
		.longest_read    (longest_read),
		.shortest_read   (shortest_read),
		.highest_quality (highest_quality),
		.lowest_quality  (lowest_quality),
		.record_length   (record_length)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= frs_pkg::QCNT_BITS'(frs_pkg::QDEPTH))
		else $error("command queue count beyond depth");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count != frs_pkg::QCNT_BITS'(frs_pkg::QDEPTH)) |-> !in_stall)
		else $error("input stalled while queue has room");

	a_error_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == 3'(frs_pkg::ST_NO_AT) ||
		               status == 3'(frs_pkg::ST_NO_NL) ||
		               status == 3'(frs_pkg::ST_NO_SEP))) |-> record_length == 16'd0)
		else $error("error result carries a record length");

	a_done_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == 3'(frs_pkg::ST_DONE)) |->
		(record_length <= longest_read && record_length >= shortest_read))
		else $error("completed record length outside longest/shortest");

endmodule

FILE: hw/rtl/frs_front.sv
// Record parser: tracks the FASTQ phase and classifies each byte into a command.
`timescale 1ns / 1ps

module frs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              is_last,
	output logic              push_valid,
	input  logic              push_stall,
	output frs_pkg::cmd_t     push_cmd
);

	frs_pkg::phase_t                  phase_q, phase_d;
	logic [15:0]                      recent_q, recent_d;
	logic [1:0]                       fill_q, fill_d;
	logic [frs_pkg::LENGTH_BITS-1:0]  seq_q, seq_d;
	logic [frs_pkg::LENGTH_BITS-1:0]  qleft_q, qleft_d;
	logic [frs_pkg::LENGTH_BITS-1:0]  qdec;
	logic                             accept;
	logic                             err;
	logic                             done;
	frs_pkg::status_t                 err_code;
	frs_pkg::cmd_t                    cmd;

	assign in_stall = push_stall;
	assign accept   = in_valid && !push_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= frs_pkg::PH_AWAIT;
			recent_q <= '0;
			fill_q   <= '0;
			seq_q    <= '0;
			qleft_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			recent_q <= recent_d;
			fill_q   <= fill_d;
			seq_q    <= seq_d;
			qleft_q  <= qleft_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		recent_d = recent_q;
		fill_d   = fill_q;
		seq_d    = seq_q;
		qleft_d  = qleft_q;
		err      = 1'b0;
		done     = 1'b0;
		err_code = frs_pkg::ST_NO_AT;
		cmd      = '0;
		qdec     = (qleft_q != '0) ? (qleft_q - frs_pkg::LENGTH_BITS'(1)) : qleft_q;

		case (phase_q)
			frs_pkg::PH_AWAIT: begin
				if (!is_last) begin
					if (data_byte == frs_pkg::CH_AT) begin
						phase_d = frs_pkg::PH_TITLE;
					end else if (data_byte == frs_pkg::CH_NL) begin
						err      = 1'b1;
						err_code = frs_pkg::ST_NO_AT;
					end
				end
			end
			frs_pkg::PH_TITLE: begin
				if (!is_last && data_byte == frs_pkg::CH_NL) begin
					phase_d  = frs_pkg::PH_SEQ;
					recent_d = '0;
					fill_d   = '0;
					seq_d    = '0;
				end
			end
			frs_pkg::PH_SEQ: begin
				if (fill_q == 2'd2 && recent_q == frs_pkg::SEP_TAIL &&
				    data_byte == frs_pkg::CH_NL) begin
					cmd.sep = 1'b1;
					qleft_d = seq_q;
					phase_d = (seq_q != '0) ? frs_pkg::PH_QUAL : frs_pkg::PH_NL;
				end else begin
					// bytes that leave the two-byte window count as sequence
					if (fill_q == 2'd2) begin
						if (!(&seq_q))
							seq_d = seq_q + frs_pkg::LENGTH_BITS'(1);
					end else begin
						fill_d = fill_q + 2'd1;
					end
					recent_d = {recent_q[7:0], data_byte};
					if (is_last) begin
						err      = 1'b1;
						err_code = frs_pkg::ST_NO_SEP;
					end
				end
			end
			frs_pkg::PH_QUAL: begin
				cmd.qual = 1'b1;
				qleft_d  = qdec;
				if (qdec == '0)
					phase_d = frs_pkg::PH_NL;
			end
			frs_pkg::PH_NL: begin
				if (data_byte == frs_pkg::CH_NL) begin
					cmd.rec = 1'b1;
					done    = 1'b1;
				end else begin
					err      = 1'b1;
					err_code = frs_pkg::ST_NO_NL;
				end
				phase_d = frs_pkg::PH_AWAIT;
			end
			default: begin
				phase_d = frs_pkg::PH_AWAIT;
			end
		endcase

		cmd.qbyte = data_byte;
		cmd.len   = seq_q;
		cmd.last  = is_last;
		cmd.emit  = is_last || err || done;
		if (err)
			cmd.status = err_code;
		else if (done && !is_last)
			cmd.status = frs_pkg::ST_DONE;
		else
			cmd.status = frs_pkg::ST_END;

		// the last byte of a buffer returns the parser to its reset state
		if (is_last) begin
			phase_d  = frs_pkg::PH_AWAIT;
			recent_d = '0;
			fill_d   = '0;
			seq_d    = '0;
			qleft_d  = '0;
		end
	end

	assign push_cmd   = cmd;
	assign push_valid = in_valid && (cmd.emit || cmd.sep || cmd.qual || cmd.rec);

endmodule

FILE: hw/rtl/frs_queue.sv
// Short command queue between the parser and the statistics side.
`timescale 1ns / 1ps

module frs_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push_valid,
	output logic                          push_stall,
	input  frs_pkg::cmd_t                 push_cmd,
	output logic                          pop_valid,
	input  logic                          pop_stall,
	output frs_pkg::cmd_t                 pop_cmd,
	output logic [frs_pkg::QCNT_BITS-1:0] count
);

	frs_pkg::cmd_t                   slot_q [frs_pkg::QDEPTH];
	logic [frs_pkg::QPTR_BITS-1:0]   wr_q;
	logic [frs_pkg::QPTR_BITS-1:0]   rd_q;
	logic [frs_pkg::QCNT_BITS-1:0]   count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_stall = (count_q == frs_pkg::QCNT_BITS'(frs_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_q];
	assign count      = count_q;
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + frs_pkg::QPTR_BITS'(1);
			if (do_pop)
				rd_q <= rd_q + frs_pkg::QPTR_BITS'(1);
			if (do_push && !do_pop)
				count_q <= count_q + frs_pkg::QCNT_BITS'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - frs_pkg::QCNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_cmd;
	end

endmodule

FILE: hw/rtl/frs_back.sv
// Statistics side: applies commands to the running totals and registers results.
`timescale 1ns / 1ps

module frs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_stall,
	input  frs_pkg::cmd_t     pop_cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [31:0]       record_count,
	output logic [39:0]       total_bases,
	output logic [15:0]       longest_read,
	output logic [15:0]       shortest_read,
	output logic [7:0]        highest_quality,
	output logic [7:0]        lowest_quality,
	output logic [15:0]       record_length
);

	logic [31:0]                     recs_q, recs_d;
	logic [frs_pkg::TOTAL_BITS-1:0]  bases_q, bases_d;
	logic [frs_pkg::TOTAL_BITS:0]    bases_sum;
	logic [frs_pkg::LENGTH_BITS-1:0] maxl_q, maxl_d;
	logic [frs_pkg::LENGTH_BITS-1:0] minl_q, minl_d;
	logic [7:0]                      maxq_q, maxq_d;
	logic [7:0]                      minq_q, minq_d;
	logic                            take;
	logic                            out_valid_q;
	frs_pkg::status_t                status_q;
	logic [31:0]                     recs_out_q;
	logic [39:0]                     bases_out_q;
	logic [15:0]                     maxl_out_q;
	logic [15:0]                     minl_out_q;
	logic [7:0]                      maxq_out_q;
	logic [7:0]                      minq_out_q;
	logic [15:0]                     len_out_q;

	// hold a result-bearing command while the output register is blocked
	assign pop_stall = pop_cmd.emit && out_valid_q && out_stall;
	assign take      = pop_valid && !pop_stall;

	always_comb begin
		maxl_d = (pop_cmd.sep && pop_cmd.len > maxl_q) ? pop_cmd.len : maxl_q;
		minl_d = (pop_cmd.sep && pop_cmd.len < minl_q) ? pop_cmd.len : minl_q;

		bases_sum = {1'b0, bases_q} + (frs_pkg::TOTAL_BITS + 1)'(pop_cmd.len);
		if (!pop_cmd.sep)
			bases_d = bases_q;
		else if (bases_sum[frs_pkg::TOTAL_BITS])
			bases_d = '1;
		else
			bases_d = bases_sum[frs_pkg::TOTAL_BITS-1:0];

		maxq_d = (pop_cmd.qual && pop_cmd.qbyte > maxq_q) ? pop_cmd.qbyte : maxq_q;
		minq_d = (pop_cmd.qual && pop_cmd.qbyte < minq_q) ? pop_cmd.qbyte : minq_q;

		recs_d = (pop_cmd.rec && !(&recs_q)) ? recs_q + 32'd1 : recs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recs_q  <= '0;
			bases_q <= '0;
			maxl_q  <= '0;
			minl_q  <= frs_pkg::MIN_LEN_RESET;
			maxq_q  <= '0;
			minq_q  <= frs_pkg::MIN_Q_RESET;
		end else if (take) begin
			if (pop_cmd.last) begin
				recs_q  <= '0;
				bases_q <= '0;
				maxl_q  <= '0;
				minl_q  <= frs_pkg::MIN_LEN_RESET;
				maxq_q  <= '0;
				minq_q  <= frs_pkg::MIN_Q_RESET;
			end else begin
				recs_q  <= recs_d;
				bases_q <= bases_d;
				maxl_q  <= maxl_d;
				minl_q  <= minl_d;
				maxq_q  <= maxq_d;
				minq_q  <= minq_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && pop_cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop_cmd.emit) begin
			status_q    <= pop_cmd.status;
			recs_out_q  <= recs_d;
			bases_out_q <= 40'(bases_d);
			maxl_out_q  <= 16'(maxl_d);
			minl_out_q  <= 16'(minl_d);
			maxq_out_q  <= maxq_d;
			minq_out_q  <= minq_d;
			len_out_q   <= pop_cmd.rec ? 16'(pop_cmd.len) : 16'd0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign record_count    = recs_out_q;
	assign total_bases     = bases_out_q;
	assign longest_read    = maxl_out_q;
	assign shortest_read   = minl_out_q;
	assign highest_quality = maxq_out_q;
	assign lowest_quality  = minq_out_q;
	assign record_length   = len_out_q;

endmodule

FILE: tb/sv/tb_fastq_record_statistics.sv
// Testbench for the FASTQ record statistics block: a record parser model and a scoreboard.
`timescale 1ns / 1ps

import frs_pkg::*;

localparam int LEN_MAX = (1 << LENGTH_BITS) - 1;

typedef struct {
	status_t                status;
	logic [31:0]            record_count;
	logic [TOTAL_BITS-1:0]  total_bases;
	logic [LENGTH_BITS-1:0] longest_read;
	logic [LENGTH_BITS-1:0] shortest_read;
	logic [7:0]             highest_quality;
	logic [7:0]             lowest_quality;
	logic [LENGTH_BITS-1:0] record_length;
} stats_result_t;

class record_scoreboard;
	phase_t                 phase;
	logic [15:0]            window;
	int                     window_fill;
	logic [LENGTH_BITS-1:0] seq_len;
	logic [LENGTH_BITS-1:0] qual_left;
	logic [LENGTH_BITS-1:0] max_len;
	logic [LENGTH_BITS-1:0] min_len;
	logic [31:0]            records;
	logic [TOTAL_BITS-1:0]  bases;
	logic [7:0]             max_q;
	logic [7:0]             min_q;
	stats_result_t          expected_q[$];
	int                     errors;
	int                     by_status[5];

	function new();
		clear_buffer();
		errors = 0;
		foreach (by_status[i]) by_status[i] = 0;
	endfunction

	function void clear_buffer();
		phase       = PH_AWAIT;
		window      = '0;
		window_fill = 0;
		seq_len     = '0;
		qual_left   = '0;
		records     = '0;
		bases       = '0;
		max_len     = '0;
		min_len     = MIN_LEN_RESET;
		max_q       = '0;
		min_q       = MIN_Q_RESET;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void push_result(status_t st, logic [LENGTH_BITS-1:0] len);
		stats_result_t r;
		r.status          = st;
		r.record_count    = records;
		r.total_bases     = bases;
		r.longest_read    = max_len;
		r.shortest_read   = min_len;
		r.highest_quality = max_q;
		r.lowest_quality  = min_q;
		r.record_length   = len;
		expected_q.push_back(r);
	endfunction

	// Advance the parser by one accepted request and queue what it produces.
	function void note_request(logic [7:0] b, logic last);
		bit                     flagged;
		status_t                st;
		logic [LENGTH_BITS-1:0] len;
		flagged = 0;
		st      = ST_DONE;
		len     = '0;
		case (phase)
		PH_AWAIT: begin
			if (!last) begin
				if (b == CH_AT) begin
					phase = PH_TITLE;
				end else if (b == CH_NL) begin
					flagged = 1;
					st      = ST_NO_AT;
				end
			end
		end
		PH_TITLE: begin
			if (!last && b == CH_NL) begin
				phase       = PH_SEQ;
				window      = '0;
				window_fill = 0;
				seq_len     = '0;
			end
		end
		PH_SEQ: begin
			if (window_fill == 2 && window == SEP_TAIL && b == CH_NL) begin
				if (seq_len > max_len) max_len = seq_len;
				if (seq_len < min_len) min_len = seq_len;
				if ({TOTAL_BITS{1'b1}} - bases < TOTAL_BITS'(seq_len))
					bases = '1;
				else
					bases = bases + TOTAL_BITS'(seq_len);
				qual_left = seq_len;
				phase     = (seq_len != 0) ? PH_QUAL : PH_NL;
			end else begin
				// bytes count only once they leave the two-byte window
				if (window_fill == 2) begin
					if (seq_len != '1) seq_len++;
				end else begin
					window_fill++;
				end
				window = {window[7:0], b};
				if (last) begin
					flagged = 1;
					st      = ST_NO_SEP;
				end
			end
		end
		PH_QUAL: begin
			if (b > max_q) max_q = b;
			if (b < min_q) min_q = b;
			if (qual_left != 0) qual_left--;
			if (qual_left == 0) phase = PH_NL;
		end
		default: begin
			flagged = 1;
			if (b == CH_NL) begin
				if (records != '1) records++;
				st  = ST_DONE;
				len = seq_len;
			end else begin
				st = ST_NO_NL;
			end
			phase = PH_AWAIT;
		end
		endcase

		if (last) begin
			if (flagged && st != ST_DONE)
				push_result(st, '0);
			else
				push_result(ST_END, len);
			clear_buffer();
		end else if (flagged) begin
			push_result(st, len);
		end
	endfunction

	function void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(stats_result_t got);
		stats_result_t want;
		if (int'(got.status) < 5) by_status[int'(got.status)]++;
		if (expected_q.size() == 0) begin
			$error("result with status %0d arrived while none was expected", got.status);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		compare_field("status", 64'(want.status), 64'(got.status));
		compare_field("record_count", 64'(want.record_count), 64'(got.record_count));
		compare_field("total_bases", 64'(want.total_bases), 64'(got.total_bases));
		compare_field("longest_read", 64'(want.longest_read), 64'(got.longest_read));
		compare_field("shortest_read", 64'(want.shortest_read), 64'(got.shortest_read));
		compare_field("highest_quality", 64'(want.highest_quality),
			64'(got.highest_quality));
		compare_field("lowest_quality", 64'(want.lowest_quality), 64'(got.lowest_quality));
		compare_field("record_length", 64'(want.record_length), 64'(got.record_length));
	endfunction
endclass

module tb_fastq_record_statistics;

	localparam int RANDOM_ITEMS   = 950;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 16;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        is_last   = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] record_count;
	logic [39:0] total_bases;
	logic [15:0] longest_read;
	logic [15:0] shortest_read;
	logic [7:0]  highest_quality;
	logic [7:0]  lowest_quality;
	logic [15:0] record_length;

	record_scoreboard board;
	bit calm          = 0;
	bit counting      = 1;
	bit hold_request  = 0;
	int counted_bytes = 0;
	int total_bytes   = 0;

	fastq_record_statistics i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.is_last        (is_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.record_count   (record_count),
		.total_bases    (total_bases),
		.longest_read   (longest_read),
		.shortest_read  (shortest_read),
		.highest_quality(highest_quality),
		.lowest_quality (lowest_quality),
		.record_length  (record_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(0, 12);
		if (r < 98) return $urandom_range(13, 80);
		return $urandom_range(81, 300);
	endfunction

	function automatic logic [7:0] base_char();
		string acgt;
		int    r;
		acgt = "ACGTN";
		r = $urandom_range(0, 99);
		if (r < 3) return CH_NL;
		if (r < 6) return SEP_TAIL[7:0];
		return acgt[$urandom_range(0, 4)];
	endfunction

	function automatic logic [7:0] quality_char();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(33, 126));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		is_last   <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(b, last);
		total_bytes++;
		if (counting) counted_bytes++;
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_at_end && (i == s.len() - 1));
	endtask

	// Drop valid and hold until every predicted result has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// One record; cut >= 0 ends the buffer at that byte, bad_tail breaks the closing newline.
	task automatic send_record(input int seq_n, input int cut, input bit bad_tail,
		input bit end_buf);
		logic [7:0] text[$];
		logic [7:0] c;
		int         qual_n;
		int         title_n;
		bit         ends;
		qual_n  = (seq_n > LEN_MAX) ? LEN_MAX : seq_n;
		title_n = $urandom_range(0, 6);
		text.push_back(CH_AT);
		repeat (title_n) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_NL) c = CH_AT;
			text.push_back(c);
		end
		text.push_back(CH_NL);
		repeat (seq_n) text.push_back(base_char());
		text.push_back(CH_NL);
		text.push_back(SEP_TAIL[7:0]);
		text.push_back(CH_NL);
		repeat (qual_n) text.push_back(quality_char());
		c = 8'($urandom_range(0, 255));
		if (c == CH_NL) c = 8'h21;
		text.push_back(bad_tail ? c : CH_NL);
		if (cut >= 0 && cut < text.size()) text = text[0:cut];
		ends = end_buf || (cut >= 0);
		foreach (text[i]) send_byte(text[i], ends && (i == text.size() - 1));
	endtask

	task automatic send_noise_line();
		logic [7:0] c;
		int         k;
		counting = 0;
		k = $urandom_range(1, 5);
		repeat (k) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_NL || c == CH_AT) c = 8'h7E;
			send_byte(c, 1'b0);
		end
		counting = 1;
	endtask

	task automatic send_garbage();
		int k;
		k = $urandom_range(1, 6);
		for (int i = 0; i < k; i++)
			send_byte(8'($urandom_range(0, 255)),
				(i == k - 1) && ($urandom_range(0, 3) == 0));
	endtask

	initial begin : stimulus
		int  pick;
		int  n;
		bit  pressure_done;
		pressure_done = 0;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero-length record, then a blank line between records
		send_text("@\n\n+\n\n", 0);
		send_byte(CH_NL, 1'b0);
		// quality extremes
		send_text("@\nAC\n+\n", 0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_NL, 1'b0);
		// missing final newline, last byte while awaiting a title, buffer cut in sequence
		send_text("@\n\n+\nX", 0);
		send_byte(CH_AT, 1'b1);
		send_text("@\nA", 1);
		wait_drained();

		counted_bytes = 0;
		while (counted_bytes < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 9) == 0);
			pick = $urandom_range(0, 99);
			n    = pick_length();
			if (pick < 62) begin
				send_record(n, -1, 0, $urandom_range(0, 19) == 0);
			end else if (pick < 70) begin
				send_record(n, -1, 1, 0);
			end else if (pick < 76) begin
				send_byte(CH_NL, 1'b0);
			end else if (pick < 82) begin
				send_noise_line();
				send_record(n, -1, 0, 0);
			end else if (pick < 92) begin
				send_record(n, $urandom_range(0, 2 * n + 12), 0, 1);
			end else begin
				send_garbage();
			end
			calm = 0;
			if ($urandom_range(0, 39) == 0) wait_drained();
			if (!pressure_done && counted_bytes > 300) begin
				// receiver holds off while records keep coming back to back
				pressure_done = 1;
				calm          = 1;
				hold_request  = 1;
				repeat (30) send_record($urandom_range(0, 4), -1, 0, 0);
				calm = 0;
				wait_drained();
			end
		end

		// one short record closes the last buffer
		send_record(3, -1, 0, 1);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Fed %0d bytes: clean, broken and cut records, gaps and a long hold.",
			total_bytes);
		$display("Results: %0d done, %0d end, %0d no-at, %0d no-nl, %0d no-sep.",
			board.by_status[int'(ST_DONE)], board.by_status[int'(ST_END)],
			board.by_status[int'(ST_NO_AT)], board.by_status[int'(ST_NO_NL)],
			board.by_status[int'(ST_NO_SEP)]);
		if (board.errors == 0 && board.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : receiver
		stats_result_t got;
		int            stall_left;
		int            free_left;
		stall_left = 0;
		free_left  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.status          = status_t'(status);
				got.record_count    = record_count;
				got.total_bases     = total_bases;
				got.longest_read    = longest_read;
				got.shortest_read   = shortest_read;
				got.highest_quality = highest_quality;
				got.lowest_quality  = lowest_quality;
				got.record_length   = record_length;
				board.check_result(got);
			end
			if (hold_request) begin
				hold_request = 0;
				stall_left   = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				out_stall <= 1'b0;
			end else begin
				out_stall  <= 1'b0;
				stall_left = pick_gap();
				free_left  = calm ? 16 : $urandom_range(0, 8);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/frs_pkg.sv
hw/rtl/frs_front.sv
hw/rtl/frs_queue.sv
hw/rtl/frs_back.sv
hw/rtl/fastq_record_statistics.sv
tb/sv/tb_fastq_record_statistics.sv
